>>> design/dwrv_pkg.sv
// ----------------------------------------------------------------------------
// dwrv_pkg
// Shared constants, types and helpers of the de-whitening repetition
// vote decoder.
// ----------------------------------------------------------------------------
package dwrv_pkg;

    localparam int MAX_WORD_BITS = 16;
    localparam int MAX_REPEATS   = 16;

    localparam int SHAPE_W    = 5;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int POS_W      = 8;
    localparam int WORD_W     = 16;
    localparam int WHITE_W    = 64;
    localparam int WHITE_ALL  = 4 * WHITE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_WORD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITENER0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHITENER1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHITENER2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WHITENER3     = 3'd5;

    localparam logic [SHAPE_W-1:0] BPW_RESET  = 5'd16;
    localparam logic [SHAPE_W-1:0] REPS_RESET = 5'd3;

    typedef struct packed {
        logic                   restart;
        logic [SHAPE_W-1:0]     bpw;
        logic [SHAPE_W-1:0]     reps;
        logic [WHITE_ALL-1:0]   whitener;
    } cfg_t;

    typedef struct packed {
        logic               step;
        logic               restart;
        logic               bit_val;
        logic [IDX_W-1:0]   bit_idx;
        logic               block_end;
    } vote_ctrl_t;

    function automatic logic [SHAPE_W-1:0] clamp_shape(input logic [SHAPE_W-1:0] v,
                                                       input logic [SHAPE_W-1:0] hi);
        logic [SHAPE_W-1:0] r;
        if (v == '0)
        begin
            r = SHAPE_W'(1);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> design/dwrv_cfg_regs.sv
// ----------------------------------------------------------------------------
// dwrv_cfg_regs
// Configuration registers: word length, repeat count and whitening bits.
// ----------------------------------------------------------------------------
module dwrv_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [dwrv_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [dwrv_pkg::CFG_DATA_W-1:0]     wr_data,
    output dwrv_pkg::cfg_t                      cfg
);

    logic [dwrv_pkg::SHAPE_W-1:0]   bpw_reg;
    logic [dwrv_pkg::SHAPE_W-1:0]   reps_reg;
    logic [dwrv_pkg::WHITE_ALL-1:0] whitener_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpw_reg      <= dwrv_pkg::BPW_RESET;
            reps_reg     <= dwrv_pkg::REPS_RESET;
            whitener_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                dwrv_pkg::REG_BITS_PER_WORD: bpw_reg  <= wr_data[dwrv_pkg::SHAPE_W-1:0];
                dwrv_pkg::REG_REPEAT_COUNT:  reps_reg <= wr_data[dwrv_pkg::SHAPE_W-1:0];
                dwrv_pkg::REG_WHITENER0:
                    whitener_reg[0*dwrv_pkg::WHITE_W +: dwrv_pkg::WHITE_W] <= wr_data;
                dwrv_pkg::REG_WHITENER1:
                    whitener_reg[1*dwrv_pkg::WHITE_W +: dwrv_pkg::WHITE_W] <= wr_data;
                dwrv_pkg::REG_WHITENER2:
                    whitener_reg[2*dwrv_pkg::WHITE_W +: dwrv_pkg::WHITE_W] <= wr_data;
                dwrv_pkg::REG_WHITENER3:
                    whitener_reg[3*dwrv_pkg::WHITE_W +: dwrv_pkg::WHITE_W] <= wr_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.restart  = wr_en && ((wr_index == dwrv_pkg::REG_BITS_PER_WORD) ||
                                 (wr_index == dwrv_pkg::REG_REPEAT_COUNT));
        cfg.bpw      = dwrv_pkg::clamp_shape(bpw_reg,
                                             dwrv_pkg::SHAPE_W'(dwrv_pkg::MAX_WORD_BITS));
        cfg.reps     = dwrv_pkg::clamp_shape(reps_reg,
                                             dwrv_pkg::SHAPE_W'(dwrv_pkg::MAX_REPEATS));
        cfg.whitener = whitener_reg;
    end

endmodule

>>> design/dwrv_seq.sv
// ----------------------------------------------------------------------------
// dwrv_seq
// Block position tracking and de-whitening of the incoming bit.
// ----------------------------------------------------------------------------
module dwrv_seq
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dwrv_pkg::cfg_t          cfg,
    input  logic                    accept,
    input  logic                    hard_bit,
    output dwrv_pkg::vote_ctrl_t    ctrl
);

    logic [dwrv_pkg::IDX_W-1:0] bit_idx_reg;
    logic [dwrv_pkg::IDX_W-1:0] rep_idx_reg;
    logic [dwrv_pkg::POS_W-1:0] pos_reg;
    logic                       word_last;
    logic                       block_end;

    assign word_last = ({1'b0, bit_idx_reg} + 5'd1) >= cfg.bpw;
    assign block_end = word_last && (({1'b0, rep_idx_reg} + 5'd1) >= cfg.reps);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_idx_reg <= '0;
            rep_idx_reg <= '0;
            pos_reg     <= '0;
        end
        else if (cfg.restart || (accept && block_end))
        begin
            bit_idx_reg <= '0;
            rep_idx_reg <= '0;
            pos_reg     <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_reg + 8'd1;
            if (word_last)
            begin
                bit_idx_reg <= '0;
                rep_idx_reg <= rep_idx_reg + 4'd1;
            end
            else
            begin
                bit_idx_reg <= bit_idx_reg + 4'd1;
            end
        end
    end

    always_comb
    begin
        ctrl.step      = accept;
        ctrl.restart   = cfg.restart;
        ctrl.bit_val   = hard_bit ^ cfg.whitener[pos_reg];
        ctrl.bit_idx   = bit_idx_reg;
        ctrl.block_end = block_end;
    end

endmodule

>>> design/dwrv_vote_bank.sv
// ----------------------------------------------------------------------------
// dwrv_vote_bank
// Per-position vote counters and the majority decision.
// ----------------------------------------------------------------------------
module dwrv_vote_bank
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dwrv_pkg::cfg_t                  cfg,
    input  dwrv_pkg::vote_ctrl_t            ctrl,
    output logic [dwrv_pkg::WORD_W-1:0]     word
);

    logic [dwrv_pkg::CNT_W-1:0] counts_reg  [dwrv_pkg::MAX_WORD_BITS];
    logic [dwrv_pkg::CNT_W-1:0] counts_next [dwrv_pkg::MAX_WORD_BITS];
    logic [dwrv_pkg::CNT_W-1:0] half;

    assign half = {1'b0, cfg.reps[dwrv_pkg::SHAPE_W-1:1]};

    always_comb
    begin
        for (int i = 0; i < dwrv_pkg::MAX_WORD_BITS; i++)
        begin
            counts_next[i] = counts_reg[i] +
                             ((ctrl.step && (ctrl.bit_idx == dwrv_pkg::IDX_W'(i))) ?
                              {4'b0, ctrl.bit_val} : 5'd0);
            word[i] = (dwrv_pkg::SHAPE_W'(i) < cfg.bpw) && (counts_next[i] > half);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dwrv_pkg::MAX_WORD_BITS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (ctrl.restart || (ctrl.step && ctrl.block_end))
        begin
            for (int i = 0; i < dwrv_pkg::MAX_WORD_BITS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < dwrv_pkg::MAX_WORD_BITS; i++)
            begin
                counts_reg[i] <= counts_next[i];
            end
        end
    end

endmodule

>>> design/dewhiten_repetition_vote_decoder_unit.sv
// ----------------------------------------------------------------------------
// dewhiten_repetition_vote_decoder_unit
// De-whitening repetition-code majority decoder, one hard bit per beat.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/hard_bit carries one coded bit per beat.
// Output channel out_valid/out_ready/decoded_word carries one word per block
// of bits_per_word * repeat_count input beats.
// Configuration is a plain write port (wr_en, wr_index, wr_data): index 0
// bits_per_word, 1 repeat_count, 2..5 whitener words 0..3. Writing either
// shape register drops the block in progress.
// Throughput: one input beat per cycle unless stalled. Latency: the decoded
// word is valid the cycle after the last bit of its block is taken. Counter
// update and majority compare sit between the position and word registers.
// Reset: shape returns to 16 bits x 3 repeats, whitening to zero, the block
// restarts and the output register is empty.
// Receiver stall: the word register holds its beat; input beats keep being
// taken until the bit that would finish the next block, which waits.
// ----------------------------------------------------------------------------
module dewhiten_repetition_vote_decoder_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                hard_bit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dwrv_pkg::WORD_W-1:0]         decoded_word,
    input  logic                                wr_en,
    input  logic [dwrv_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [dwrv_pkg::CFG_DATA_W-1:0]     wr_data
);

    dwrv_pkg::cfg_t                 cfg;
    dwrv_pkg::vote_ctrl_t           ctrl;
    logic [dwrv_pkg::WORD_W-1:0]    word;
    logic                           accept;
    logic                           out_valid_reg;
    logic [dwrv_pkg::WORD_W-1:0]    word_reg;

    assign in_ready     = !(out_valid_reg && !out_ready && ctrl.block_end);
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign decoded_word = word_reg;

    dwrv_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    dwrv_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .hard_bit (hard_bit),
        .ctrl     (ctrl)
    );

    dwrv_vote_bank u_vote_bank
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .ctrl  (ctrl),
        .word  (word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && ctrl.block_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && ctrl.block_end)
        begin
            word_reg <= word;
        end
    end

endmodule

>>> design/dwrv_checker.sv
// ----------------------------------------------------------------------------
// dwrv_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dwrv_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [dwrv_pkg::WORD_W-1:0]         decoded_word
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(decoded_word))
        else $error("output beat changed while stalled");

    // empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // a word only follows an accepted bit
    a_word_from_bit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("word appeared without an input beat");

    // taken word without a new bit leaves output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
        else $error("word repeated");

endmodule

bind dewhiten_repetition_vote_decoder_unit dwrv_checker u_dwrv_checker (.*);

>>> verif/tb_dewhiten_repetition_vote_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_dewhiten_repetition_vote_decoder_unit
// Self-checking bench for the de-whitening repetition vote decoder.
// ----------------------------------------------------------------------------
// Hard bits are sent as repeated, whitened codewords with random noise, plus
// partial blocks and pure noise. A bit-level vote tally kept in the bench
// predicts each decoded word. Every output beat is compared in order. Shape
// and whitening registers are changed between phases, including values out of
// range. Both channels idle at random, and one phase holds the output off
// long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_dewhiten_repetition_vote_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 300;

    localparam logic [dwrv_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [dwrv_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               in_valid     = 1'b0;
    logic                               in_ready;
    logic                               hard_bit     = 1'b0;
    logic                               out_valid;
    logic                               out_ready    = 1'b0;
    logic [dwrv_pkg::WORD_W-1:0]        decoded_word;
    logic                               wr_en        = 1'b0;
    logic [dwrv_pkg::CFG_IDX_W-1:0]     wr_index     = '0;
    logic [dwrv_pkg::CFG_DATA_W-1:0]    wr_data      = '0;

    // vote tally of the bench
    logic [dwrv_pkg::SHAPE_W-1:0]       cfg_word_bits;
    logic [dwrv_pkg::SHAPE_W-1:0]       cfg_repeats;
    logic [dwrv_pkg::WHITE_W-1:0]       white_bits [4];
    logic [dwrv_pkg::CNT_W-1:0]         tally [dwrv_pkg::MAX_WORD_BITS];
    logic [dwrv_pkg::IDX_W-1:0]         word_pos;
    logic [dwrv_pkg::IDX_W-1:0]         rep_pos;
    logic [dwrv_pkg::POS_W-1:0]         chip_pos;

    logic [dwrv_pkg::WORD_W-1:0]        expected_words [$];
    logic [dwrv_pkg::WORD_W-1:0]        want_word;
    int                                 err_count     = 0;
    int                                 items_sent    = 0;
    int                                 quiet_cycles  = 0;
    int                                 send_idle_pct = 10;
    int                                 recv_idle_pct = 70;
    int                                 hold_request  = 0;
    int                                 hold_served   = 0;
    int                                 hold_left     = 0;

    dewhiten_repetition_vote_decoder_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .hard_bit     (hard_bit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .decoded_word (decoded_word),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #1 clk = ~clk;

    function automatic int eff_len(input logic [dwrv_pkg::SHAPE_W-1:0] v, input int hi);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > hi)
        begin
            return hi;
        end
        return int'(v);
    endfunction

    function automatic int block_bits();
        return eff_len(cfg_word_bits, dwrv_pkg::MAX_WORD_BITS) *
               eff_len(cfg_repeats, dwrv_pkg::MAX_REPEATS);
    endfunction

    function automatic void clear_block();
        foreach (tally[i])
        begin
            tally[i] = '0;
        end
        word_pos = '0;
        rep_pos  = '0;
        chip_pos = '0;
    endfunction

    function automatic logic white_at();
        return white_bits[chip_pos[7:6]][chip_pos[5:0]];
    endfunction

    function automatic void apply_write(input logic [dwrv_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [dwrv_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            dwrv_pkg::REG_BITS_PER_WORD:
            begin
                cfg_word_bits = data[dwrv_pkg::SHAPE_W-1:0];
                clear_block();
            end
            dwrv_pkg::REG_REPEAT_COUNT:
            begin
                cfg_repeats = data[dwrv_pkg::SHAPE_W-1:0];
                clear_block();
            end
            dwrv_pkg::REG_WHITENER0: white_bits[0] = data;
            dwrv_pkg::REG_WHITENER1: white_bits[1] = data;
            dwrv_pkg::REG_WHITENER2: white_bits[2] = data;
            dwrv_pkg::REG_WHITENER3: white_bits[3] = data;
            default: ;
        endcase
    endfunction

    function automatic void tally_bit(input logic b);
        int                             nbits;
        int                             nreps;
        logic                           v;
        logic [dwrv_pkg::WORD_W-1:0]    word;
        nbits = eff_len(cfg_word_bits, dwrv_pkg::MAX_WORD_BITS);
        nreps = eff_len(cfg_repeats, dwrv_pkg::MAX_REPEATS);
        v = b ^ white_at();
        tally[word_pos] = tally[word_pos] + dwrv_pkg::CNT_W'(v);
        if (int'(word_pos) + 1 >= nbits)
        begin
            word_pos = '0;
            if (int'(rep_pos) + 1 >= nreps)
            begin
                word = '0;
                for (int i = 0; i < nbits; i++)
                begin
                    if (int'(tally[i]) > nreps / 2)
                    begin
                        word[i] = 1'b1;
                    end
                end
                expected_words.push_back(word);
                clear_block();
                return;
            end
            rep_pos = rep_pos + 4'd1;
        end
        else
        begin
            word_pos = word_pos + 4'd1;
        end
        chip_pos = chip_pos + 8'd1;
    endfunction

    function automatic logic coded_bit(input logic [dwrv_pkg::WORD_W-1:0] word,
                                       input int noise_pct);
        logic flip;
        flip = ($urandom_range(0, 99) < noise_pct);
        return word[word_pos] ^ white_at() ^ flip;
    endfunction

    function automatic logic [dwrv_pkg::CFG_DATA_W-1:0] shape_data(
        input logic [dwrv_pkg::SHAPE_W-1:0] v);
        logic [dwrv_pkg::CFG_DATA_W-1:0] d;
        d = {$urandom(), $urandom()};
        d[dwrv_pkg::SHAPE_W-1:0] = v;
        return d;
    endfunction

    function automatic logic [dwrv_pkg::SHAPE_W-1:0] rand_shape();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return dwrv_pkg::SHAPE_W'($urandom_range(17, 31));
            2:       return dwrv_pkg::SHAPE_W'(16);
            3:       return dwrv_pkg::SHAPE_W'(1);
            default: return dwrv_pkg::SHAPE_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [dwrv_pkg::CFG_DATA_W-1:0] rand_white();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic int rand_noise();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 25;
            default: return 50;
        endcase
    endfunction

    task automatic send_bit(input logic b);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        hard_bit <= b;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        tally_bit(b);
        items_sent++;
    endtask

    // runs to the end of the block in progress
    task automatic send_block(input logic [dwrv_pkg::WORD_W-1:0] word, input int noise_pct);
        do
            send_bit(coded_bit(word, noise_pct));
        while (chip_pos != '0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dwrv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dwrv_pkg::CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        apply_write(idx, data);
        @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic test_default_shape();
        send_block(dwrv_pkg::WORD_W'($urandom), 25);
        send_block(dwrv_pkg::WORD_W'($urandom), 0);
    endtask

    task automatic test_shape_clamp_low();
        settle();
        write_reg(dwrv_pkg::REG_BITS_PER_WORD, shape_data('0));
        write_reg(dwrv_pkg::REG_REPEAT_COUNT, shape_data('0));
        write_reg(dwrv_pkg::REG_WHITENER0, '1);
        send_bit(1'b0);
        send_bit(1'b1);
    endtask

    task automatic test_tie_and_restart();
        settle();
        write_reg(dwrv_pkg::REG_BITS_PER_WORD, shape_data(dwrv_pkg::SHAPE_W'(2)));
        write_reg(dwrv_pkg::REG_REPEAT_COUNT, shape_data(dwrv_pkg::SHAPE_W'(2)));
        write_reg(dwrv_pkg::REG_WHITENER0, '0);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        settle();
        write_reg(dwrv_pkg::REG_REPEAT_COUNT, shape_data(dwrv_pkg::SHAPE_W'(1)));
        send_bit(1'b1);
        send_bit(1'b0);
    endtask

    task automatic test_shape_clamp_high();
        settle();
        write_reg(dwrv_pkg::REG_BITS_PER_WORD, shape_data(dwrv_pkg::SHAPE_W'(31)));
        write_reg(dwrv_pkg::REG_WHITENER0, {$urandom(), $urandom()});
        repeat (16) send_bit($urandom_range(0, 1));
    endtask

    task automatic test_random(input int budget);
        int                             stop;
        int                             nblk;
        int                             noise;
        logic [dwrv_pkg::WORD_W-1:0]    word;
        stop = items_sent + budget;
        while (items_sent < stop)
        begin
            settle();
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(dwrv_pkg::REG_BITS_PER_WORD, shape_data(dwrv_pkg::SHAPE_W'(16)));
                write_reg(dwrv_pkg::REG_REPEAT_COUNT, shape_data(dwrv_pkg::SHAPE_W'(16)));
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    write_reg(dwrv_pkg::REG_BITS_PER_WORD, shape_data(rand_shape()));
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    write_reg(dwrv_pkg::REG_REPEAT_COUNT, shape_data(rand_shape()));
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    write_reg(dwrv_pkg::CFG_IDX_W'(dwrv_pkg::REG_WHITENER0 + k), rand_white());
                end
            end
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          {$urandom(), $urandom()});
            end
            nblk  = (block_bits() > 64) ? 1 : $urandom_range(1, 4);
            noise = rand_noise();
            word  = dwrv_pkg::WORD_W'($urandom);
            repeat (nblk) send_block(dwrv_pkg::WORD_W'($urandom), noise);
            if (block_bits() > 1 && $urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, block_bits() - 1)) send_bit(coded_bit(word, noise));
                if ($urandom_range(0, 1) == 1)
                begin
                    // whitening change in mid-block keeps the block
                    settle();
                    write_reg(dwrv_pkg::CFG_IDX_W'(dwrv_pkg::REG_WHITENER0 +
                                                   $urandom_range(0, 3)),
                              rand_white());
                    send_block(word, noise);
                end
            end
        end
    endtask

    task automatic test_output_stall();
        settle();
        write_reg(dwrv_pkg::REG_BITS_PER_WORD, shape_data(dwrv_pkg::SHAPE_W'(2)));
        write_reg(dwrv_pkg::REG_REPEAT_COUNT, shape_data(dwrv_pkg::SHAPE_W'(1)));
        hold_request <= hold_request + 1;
        repeat (20) send_block(dwrv_pkg::WORD_W'($urandom), 0);
    endtask

    always @(posedge clk)
    begin
        if (hold_request != hold_served)
        begin
            hold_served = hold_request;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("decoded_word: expected none, actual %h", decoded_word);
                err_count++;
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (decoded_word !== want_word)
                begin
                    $error("decoded_word: expected %h, actual %h", want_word, decoded_word);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
        begin
            quiet_cycles++;
        end
        else
        begin
            quiet_cycles = 0;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        cfg_word_bits = dwrv_pkg::BPW_RESET;
        cfg_repeats   = dwrv_pkg::REPS_RESET;
        foreach (white_bits[i])
        begin
            white_bits[i] = '0;
        end
        clear_block();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(10, 70);
        test_default_shape();
        test_shape_clamp_low();
        test_tie_and_restart();
        test_shape_clamp_high();
        test_random(250);
        set_idling(70, 10);
        test_random(250);
        set_idling(0, 0);
        test_random(250);
        test_output_stall();
        settle();

        if (err_count == 0 && expected_words.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
